// ===== rtl/sdr_pkg.sv =====
// Shared constants, types and control structs for the stream duplicate remover.
// No dependencies; every other file in rtl/ except sdr_ram imports this package.

package sdr_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int DIST_W      = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } sdr_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } sdr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } sdr_status_type;

endpackage

// ===== rtl/sdr_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
// Depends on sdr_pkg for field widths.

interface sdr_req_if import sdr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface sdr_rsp_if import sdr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value_out;
   logic                      keep;
   logic [DIST_W-1:0]         distinct_count;
   logic                      overflow;
   logic                      last_out;

   modport source (output valid, output value_out, output keep, output distinct_count,
                   output overflow, output last_out, input ready);
   modport sink   (input valid, input value_out, input keep, input distinct_count,
                   input overflow, input last_out, output ready);
endinterface

// ===== rtl/stream_duplicate_remover.sv =====
// Channel   Dir  Handshake          Payload
// req_ch    in   valid/ready        value[31:0] signed, last
// rsp_ch    out  valid/ready        value_out, keep, distinct_count[6:0], overflow, last_out
//
// The table RAM, with registered read data, is read one entry per cycle until a match
// or the end of the stored entries, of which there are 0..64; the next request is
// accepted only once the current one is scanned and committed. Reset (synchronous)
// empties the table by clearing the stored count.
// A finished result waits in the response register while the next transaction is
// accepted and scanned; the commit stalls only while that register is still full.
// Depends on sdr_pkg, sdr_if, sdr_ram, sdr_ctrl and sdr_datapath.

module stream_duplicate_remover import sdr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sdr_req_if.sink   req_ch,
   sdr_rsp_if.source rsp_ch
);

   sdr_cmd_type    cmd;
   sdr_status_type status;
   logic           req_ready;

   sdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_ch.value),
      .req_last  (req_ch.last),
      .cmd       (cmd),
      .status    (status),
      .rsp_ch    (rsp_ch)
   );

   assign req_ch.ready = req_ready;

endmodule

// ===== rtl/sdr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module sdr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sdr_ctrl.sv =====
// Control state machine: accept, scan the table, commit the result.
// Depends on sdr_pkg for the state enum and the command/status structs.

module sdr_ctrl import sdr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  sdr_status_type status,
   output sdr_cmd_type    cmd
);

   sdr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register can take the result
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.commit = status.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/sdr_datapath.sv =====
// Datapath: transaction latch, table scan pointer, compare, stored count and
// response register. Depends on sdr_pkg, sdr_if and sdr_ram.

module sdr_datapath import sdr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   input  sdr_cmd_type               cmd,
   output sdr_status_type            status,
   sdr_rsp_if.source                 rsp_ch
);

   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      last_ff, last_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      pend_ff, pend_in;
   logic                      found_ff, found_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_keep_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_last_ff;

   logic [VALUE_W-1:0]        rd_data;
   logic                      hit;
   logic                      issue;
   logic                      insert;
   logic [CNT_W-1:0]          cnt_next;
   logic [CNT_W+DIST_W-1:0]   dist_wide;

   sdr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.commit && insert),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ($unsigned(val_ff)),
      .rd_en   (issue),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // read data comes back in the cycle after the address, so compare against the pending read
   assign hit    = pend_ff && (rd_data == $unsigned(val_ff));
   assign issue  = cmd.scan && !found_ff && (idx_ff < count_ff);
   assign insert = !found_ff && (count_ff < CNT_W'(TABLE_DEPTH));
   assign cnt_next  = count_ff + CNT_W'(insert);
   assign dist_wide = (CNT_W+DIST_W)'(cnt_next);

   assign status.scan_done = !pend_ff && (found_ff || (idx_ff == count_ff));
   assign status.rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      val_in   = val_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      pend_in  = issue;
      found_in = found_ff | hit;
      if (cmd.load) begin
         val_in   = req_value;
         last_in  = req_last;
         idx_in   = '0;
         found_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.commit) begin
         // empty the table after the final transaction of a sequence
         count_in = last_ff ? '0 : cnt_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      last_ff <= last_in;
      if (cmd.commit) begin
         rsp_value_ff <= val_ff;
         rsp_keep_ff  <= insert;
         rsp_dist_ff  <= dist_wide[DIST_W-1:0];
         rsp_ovf_ff   <= !found_ff && !insert;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.value_out      = rsp_value_ff;
   assign rsp_ch.keep           = rsp_keep_ff;
   assign rsp_ch.distinct_count = rsp_dist_ff;
   assign rsp_ch.overflow       = rsp_ovf_ff;
   assign rsp_ch.last_out       = rsp_last_ff;

endmodule
